// ===== rtl/core/cmf4_pkg.sv =====
// Shared types, constants and field positions for the cmap format 4 glyph mapper.
`default_nettype none

package cmf4_pkg;

  localparam int MAX_SEGMENTS      = 256;
  localparam int GLYPH_ARRAY_DEPTH = 1024;

  localparam int SEG_AW  = $clog2(MAX_SEGMENTS);
  localparam int GA_AW   = $clog2(GLYPH_ARRAY_DEPTH);
  localparam int NSEG_W  = SEG_AW + 1;
  // Word index into the glyph array, signed, wide enough for
  // segment + offset/2 + (code - start) minus the segment count.
  localparam int IDX_W   = $clog2(MAX_SEGMENTS + 32768 + 65536) + 1;

  localparam int CODE_W  = 16;
  localparam int INDEX_W = 10;
  localparam int OP_W    = 2;
  localparam int CFG_W   = 9;

  localparam logic [CODE_W-1:0] SENTINEL_CODE = 16'hFFFF;

  // Request kinds carried on the input tuser.
  localparam logic [OP_W-1:0] OP_LOAD_SEG   = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_GLYPH = 2'd1;
  localparam logic [OP_W-1:0] OP_MAP        = 2'd2;

  // Input tdata layout, lowest bits first.
  localparam int IN_INDEX_LSB = 0;
  localparam int IN_END_LSB   = IN_INDEX_LSB + INDEX_W;
  localparam int IN_START_LSB = IN_END_LSB + CODE_W;
  localparam int IN_DELTA_LSB = IN_START_LSB + CODE_W;
  localparam int IN_RO_LSB    = IN_DELTA_LSB + CODE_W;
  localparam int IN_GW_LSB    = IN_RO_LSB + CODE_W;
  localparam int IN_CHAR_LSB  = IN_GW_LSB + CODE_W;
  localparam int IN_BITS      = IN_CHAR_LSB + CODE_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

  // Output tdata layout, lowest bits first.
  localparam int OUT_BITS     = CODE_W + 2;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [CODE_W-1:0] range_offset;
    logic [CODE_W-1:0] id_delta;
    logic [CODE_W-1:0] start_code;
    logic [CODE_W-1:0] end_code;
  } seg_entry_t;

  typedef struct packed {
    logic wr_seg;
    logic wr_glyph;
    logic start;
    logic seg_rd;
    logic next_k;
    logic calc;
    logic glyph_rd;
    logic set_miss;
    logic set_delta;
    logic set_oob;
    logic set_glyph;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic nseg_zero;
    logic sentinel;
    logic end_ge;
    logic start_gt;
    logic ro_zero;
    logic last;
    logic oob;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/cmf4_datapath.sv =====
// Datapath: segment and glyph stores, segment compare, index arithmetic, output register.
`default_nettype none

module cmf4_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [cmf4_pkg::CFG_W-1:0]     cfg_value,
  input  wire logic [cmf4_pkg::IN_TDATA_W-1:0] in_data,
  input  wire cmf4_pkg::ctrl_cmd_t            cmd,
  output cmf4_pkg::dp_status_t                status,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [cmf4_pkg::OUT_TDATA_W-1:0]    out_data
);
  import cmf4_pkg::*;

  seg_entry_t        seg_mem [MAX_SEGMENTS];
  logic [CODE_W-1:0] glyph_mem [GLYPH_ARRAY_DEPTH];

  logic [CFG_W-1:0]   segment_count;
  logic [NSEG_W-1:0]  nseg;
  logic [SEG_AW-1:0]  k;
  logic [CODE_W-1:0]  code;
  seg_entry_t         seg_q;
  logic [CODE_W-1:0]  glyph_q;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   idx_next;
  logic [NSEG_W-1:0]  nseg_next;
  logic [CODE_W-1:0]  res_glyph;
  logic               res_hit;
  logic               res_miss;

  logic [INDEX_W-1:0] in_index;
  seg_entry_t         in_seg;
  logic [CODE_W-1:0]  in_glyph_word;
  logic [CODE_W-1:0]  in_char;

  assign in_index               = in_data[IN_INDEX_LSB +: INDEX_W];
  assign in_seg.end_code        = in_data[IN_END_LSB +: CODE_W];
  assign in_seg.start_code      = in_data[IN_START_LSB +: CODE_W];
  assign in_seg.id_delta        = in_data[IN_DELTA_LSB +: CODE_W];
  assign in_seg.range_offset    = in_data[IN_RO_LSB +: CODE_W];
  assign in_glyph_word          = in_data[IN_GW_LSB +: CODE_W];
  assign in_char                = in_data[IN_CHAR_LSB +: CODE_W];

  // The search length saturates at the store depth.
  assign nseg_next = (32'(segment_count) > MAX_SEGMENTS) ? NSEG_W'(MAX_SEGMENTS)
                                                         : NSEG_W'(segment_count);

  assign idx_next = IDX_W'(k) + IDX_W'(seg_q.range_offset >> 1)
                  + IDX_W'(code - seg_q.start_code) - IDX_W'(nseg);

  assign status.nseg_zero = (nseg == '0);
  assign status.sentinel  = (seg_q.end_code == SENTINEL_CODE);
  assign status.end_ge    = (seg_q.end_code >= code);
  assign status.start_gt  = (seg_q.start_code > code);
  assign status.ro_zero   = (seg_q.range_offset == '0);
  assign status.last      = ((NSEG_W'(k) + NSEG_W'(1)) >= nseg);
  assign status.oob       = idx[IDX_W-1] || (idx >= IDX_W'(GLYPH_ARRAY_DEPTH));
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.wr_seg && (32'(in_index) < MAX_SEGMENTS)) begin
      seg_mem[SEG_AW'(in_index)] <= in_seg;
    end
    if (cmd.seg_rd) begin
      seg_q <= seg_mem[k];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_glyph && (32'(in_index) < GLYPH_ARRAY_DEPTH)) begin
      glyph_mem[GA_AW'(in_index)] <= in_glyph_word;
    end
    if (cmd.glyph_rd) begin
      glyph_q <= glyph_mem[idx[GA_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= CFG_W'(1);
    end else if (cfg_we) begin
      segment_count <= cfg_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      code <= in_char;
      nseg <= nseg_next;
      k    <= '0;
    end else if (cmd.next_k) begin
      k <= k + SEG_AW'(1);
    end
    if (cmd.calc) begin
      idx <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_miss) begin
      res_glyph <= '0;
      res_hit   <= 1'b0;
      res_miss  <= 1'b0;
    end else if (cmd.set_delta) begin
      res_glyph <= seg_q.id_delta + code;
      res_hit   <= 1'b1;
      res_miss  <= 1'b0;
    end else if (cmd.set_oob) begin
      res_glyph <= '0;
      res_hit   <= 1'b1;
      res_miss  <= 1'b1;
    end else if (cmd.set_glyph) begin
      // A zero word stays the missing glyph; the delta applies otherwise.
      res_glyph <= (glyph_q == '0) ? '0 : glyph_q + seg_q.id_delta;
      res_hit   <= 1'b1;
      res_miss  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= OUT_TDATA_W'({res_miss, res_hit, res_glyph});
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cmf4_ctrl.sv =====
// Controller: sequences loads, the linear segment scan and the glyph array lookup.
`default_nettype none

module cmf4_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire logic [cmf4_pkg::OP_W-1:0] in_op,
  output logic                          in_ready,
  input  wire cmf4_pkg::dp_status_t     status,
  output cmf4_pkg::ctrl_cmd_t           cmd
);
  import cmf4_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_TEST,
    S_CALC,
    S_ARRAY,
    S_GLYPH,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.wr_seg   = accept && (in_op == OP_LOAD_SEG);
        cmd.wr_glyph = accept && (in_op == OP_LOAD_GLYPH);
        if (accept && (in_op == OP_MAP)) begin
          cmd.start  = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (status.nseg_zero) begin
          cmd.set_miss = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.seg_rd = 1'b1;
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        if (status.sentinel) begin
          cmd.set_miss = 1'b1;
          state_next   = S_DONE;
        end else if (status.end_ge) begin
          if (status.start_gt) begin
            cmd.set_miss = 1'b1;
            state_next   = S_DONE;
          end else if (status.ro_zero) begin
            cmd.set_delta = 1'b1;
            state_next    = S_DONE;
          end else begin
            cmd.calc   = 1'b1;
            state_next = S_ARRAY;
          end
        end else if (status.last) begin
          cmd.set_miss = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.next_k = 1'b1;
          state_next = S_READ;
        end
      end
      S_CALC: begin
        state_next = S_ARRAY;
      end
      S_ARRAY: begin
        if (status.oob) begin
          cmd.set_oob = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.glyph_rd = 1'b1;
          state_next   = S_GLYPH;
        end
      end
      S_GLYPH: begin
        cmd.set_glyph = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        // Hold the result until the output register can take it.
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cmap_format4_glyph_mapper.sv =====
// Top level of the cmap format 4 glyph mapper.
`default_nettype none

// Holds one cmap format 4 subtable (up to 256 segments and a 1024-word glyph
// array) and maps character codes to glyph indices. A load request is written
// into its store when it is accepted. A map request scans the segments in stored
// order through the registered segment store read. The segment that ends the
// search gives a miss, a delta result for a zero range offset, or a glyph
// array index that is checked against the store and, when inside it, read from
// the glyph array; a segment count of zero gives a miss without a segment read.
// The next request is accepted from the cycle after the result is loaded. One
// request is worked on at a time, and a finished result waits in the output
// register while the next request is accepted; a result that finds that
// register still full waits until it drains. The user must write the segment
// count register through the cfg port only while no request is in work; the
// block itself does not enforce it.
module cmap_format4_glyph_mapper (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [cmf4_pkg::CFG_W-1:0]      cfg_data,      // segment_count
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // index, end_code, start_code, id_delta, range_offset, glyph_word, char_code
  input  wire logic [cmf4_pkg::IN_TDATA_W-1:0] s_tdata,
  input  wire logic [cmf4_pkg::OP_W-1:0]       s_tuser,       // op
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [cmf4_pkg::OUT_TDATA_W-1:0]     m_tdata        // glyph_id, segment_hit, array_miss
);
  import cmf4_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  cmf4_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (s_tuser),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cmf4_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_value (cfg_data),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire

// ===== rtl/core/cmf4_checker.sv =====
// Port-level checks for the cmap format 4 glyph mapper, bound to the top level.
`default_nettype none

module cmf4_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic [cmf4_pkg::OP_W-1:0]       s_tuser,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [cmf4_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import cmf4_pkg::*;

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or dropped while stalled");

  // An array miss only happens inside a found segment.
  a_miss_has_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[CODE_W+1] || m_tdata[CODE_W])
    else $error("array_miss without segment_hit");

  // Every miss reports the missing glyph.
  a_miss_glyph_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (!m_tdata[CODE_W] || m_tdata[CODE_W+1]) |-> m_tdata[CODE_W-1:0] == '0)
    else $error("miss with nonzero glyph_id");

  // A map request keeps the block busy for at least the next cycle.
  a_map_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == OP_MAP) |=> !s_tready)
    else $error("request accepted right after a map request");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind cmap_format4_glyph_mapper cmf4_checker u_cmf4_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the cmap format 4 glyph mapper with random segment tables.
`timescale 1ns / 100ps

module tb_top;
  import cmf4_pkg::*;

  // The fourth request kind is accepted and dropped by the block.
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned TAIL_CYCLES   = 64;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] index;
    logic [CODE_W-1:0]  end_code;
    logic [CODE_W-1:0]  start_code;
    logic [CODE_W-1:0]  id_delta;
    logic [CODE_W-1:0]  range_offset;
    logic [CODE_W-1:0]  glyph_word;
    logic [CODE_W-1:0]  char_code;
  } map_req_t;

  // Same order as the output tdata, glyph_id in the lowest bits.
  typedef struct packed {
    logic              array_miss;
    logic              segment_hit;
    logic [CODE_W-1:0] glyph_id;
  } glyph_result_t;

  class glyph_map_scoreboard;
    bit [CODE_W-1:0] end_mem   [MAX_SEGMENTS];
    bit [CODE_W-1:0] start_mem [MAX_SEGMENTS];
    bit [CODE_W-1:0] delta_mem [MAX_SEGMENTS];
    bit [CODE_W-1:0] ro_mem    [MAX_SEGMENTS];
    bit [CODE_W-1:0] glyph_mem [GLYPH_ARRAY_DEPTH];
    bit              seg_written   [MAX_SEGMENTS];
    bit              glyph_written [GLYPH_ARRAY_DEPTH];
    int unsigned     seg_count;
    glyph_result_t   pending [$];
    int unsigned     mismatches;
    int unsigned     maps_checked;
    int unsigned     hits;
    int unsigned     array_misses;
    int unsigned     accepted;

    function new();
      seg_count = 1;
    endfunction

    function int unsigned search_len();
      return (seg_count > MAX_SEGMENTS) ? MAX_SEGMENTS : seg_count;
    endfunction

    // Walks the segments like the block does. slot is the glyph array word that
    // gets read (or -1), seg_ok is cleared if any segment read was never loaded.
    function glyph_result_t lookup(bit [CODE_W-1:0] code, output int slot, output bit seg_ok);
      glyph_result_t res;
      int unsigned   nseg;
      int unsigned   k;
      int unsigned   found;
      bit            have;
      longint        gidx;
      res    = '0;
      slot   = -1;
      seg_ok = 1'b1;
      have   = 1'b0;
      found  = 0;
      nseg   = search_len();
      for (k = 0; k < nseg; k++) begin
        if (!seg_written[k]) seg_ok = 1'b0;
        if (end_mem[k] == SENTINEL_CODE) break;
        if (end_mem[k] >= code) begin
          found = k;
          have  = 1'b1;
          break;
        end
      end
      if (have && start_mem[found] > code) have = 1'b0;
      if (have) begin
        res.segment_hit = 1'b1;
        if (ro_mem[found] == 0) begin
          res.glyph_id = delta_mem[found] + code;
        end else begin
          gidx = longint'(found) + longint'(ro_mem[found] >> 1) + longint'(code)
                 - longint'(start_mem[found]) - longint'(nseg);
          if (gidx < 0 || gidx >= GLYPH_ARRAY_DEPTH) begin
            res.array_miss = 1'b1;
          end else begin
            slot = int'(gidx);
            res.glyph_id = glyph_mem[slot];
            if (res.glyph_id != 0) res.glyph_id = res.glyph_id + delta_mem[found];
          end
        end
      end
      return res;
    endfunction

    function void note_request(map_req_t r);
      int slot;
      bit seg_ok;
      accepted++;
      case (r.op)
        OP_LOAD_SEG: begin
          if (r.index < MAX_SEGMENTS) begin
            end_mem[r.index[SEG_AW-1:0]]     = r.end_code;
            start_mem[r.index[SEG_AW-1:0]]   = r.start_code;
            delta_mem[r.index[SEG_AW-1:0]]   = r.id_delta;
            ro_mem[r.index[SEG_AW-1:0]]      = r.range_offset;
            seg_written[r.index[SEG_AW-1:0]] = 1'b1;
          end
        end
        OP_LOAD_GLYPH: begin
          if (r.index < GLYPH_ARRAY_DEPTH) begin
            glyph_mem[r.index]     = r.glyph_word;
            glyph_written[r.index] = 1'b1;
          end
        end
        OP_MAP: pending.push_back(lookup(r.char_code, slot, seg_ok));
        default: ;
      endcase
    endfunction

    function void report(string what, glyph_result_t want, glyph_result_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%s: expected glyph %h hit %0d miss %0d, got glyph %h hit %0d miss %0d",
                 what, want.glyph_id, want.segment_hit, want.array_miss,
                 got.glyph_id, got.segment_hit, got.array_miss);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d);
      glyph_result_t want;
      glyph_result_t got;
      got = d[OUT_BITS-1:0];
      if (pending.size() == 0) begin
        report("result with no map request outstanding", '0, got);
        return;
      end
      want = pending.pop_front();
      maps_checked++;
      if (want.segment_hit) hits++;
      if (want.array_miss) array_misses++;
      if (got.glyph_id !== want.glyph_id || got.segment_hit !== want.segment_hit ||
          got.array_miss !== want.array_miss)
        report("map result mismatch", want, got);
    endfunction
  endclass

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic [OP_W-1:0]        s_tuser   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  idle_mode_t          idle_mode     = IDLE_NONE;
  int unsigned         hold_requests = 0;
  int unsigned         hold_served   = 0;
  int unsigned         hold_left     = 0;
  glyph_map_scoreboard sb;

  cmap_format4_glyph_mapper u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  function automatic bit coin(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int unsigned send_idle_pct();
    return (idle_mode == IDLE_SEND) ? 47 : (idle_mode == IDLE_BOTH) ? 22 : 0;
  endfunction

  function automatic int unsigned recv_stall_pct();
    return (idle_mode == IDLE_RECV) ? 47 : (idle_mode == IDLE_BOTH) ? 22 : 0;
  endfunction

  // Result side: check on every accepted result, then pick the next ready.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else if (hold_served != hold_requests) begin
        hold_served <= hold_requests;
        hold_left   <= LONG_HOLD;
        m_tready    <= 1'b0;
      end else begin
        m_tready <= !coin(recv_stall_pct());
      end
    end
  end

  function automatic map_req_t rand_req(logic [OP_W-1:0] op);
    map_req_t r;
    r.op           = op;
    r.index        = INDEX_W'($urandom);
    r.end_code     = CODE_W'($urandom);
    r.start_code   = CODE_W'($urandom);
    r.id_delta     = CODE_W'($urandom);
    r.range_offset = CODE_W'($urandom);
    r.glyph_word   = CODE_W'($urandom);
    r.char_code    = CODE_W'($urandom);
    return r;
  endfunction

  function automatic map_req_t seg_load(int unsigned idx, bit [CODE_W-1:0] e,
                                        bit [CODE_W-1:0] s, bit [CODE_W-1:0] d,
                                        bit [CODE_W-1:0] ro);
    map_req_t r;
    r              = rand_req(OP_LOAD_SEG);
    r.index        = idx[INDEX_W-1:0];
    r.end_code     = e;
    r.start_code   = s;
    r.id_delta     = d;
    r.range_offset = ro;
    return r;
  endfunction

  function automatic map_req_t glyph_load(int unsigned idx, bit [CODE_W-1:0] w);
    map_req_t r;
    r            = rand_req(OP_LOAD_GLYPH);
    r.index      = idx[INDEX_W-1:0];
    r.glyph_word = w;
    return r;
  endfunction

  // Holds the request on the bus until the block takes it. tvalid is only
  // lowered while waiting out a gap, never in the step it is raised again.
  task automatic push_req(map_req_t r);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[IN_INDEX_LSB +: INDEX_W] = r.index;
    d[IN_END_LSB   +: CODE_W]  = r.end_code;
    d[IN_START_LSB +: CODE_W]  = r.start_code;
    d[IN_DELTA_LSB +: CODE_W]  = r.id_delta;
    d[IN_RO_LSB    +: CODE_W]  = r.range_offset;
    d[IN_GW_LSB    +: CODE_W]  = r.glyph_word;
    d[IN_CHAR_LSB  +: CODE_W]  = r.char_code;
    while (coin(send_idle_pct())) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= r.op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(r);
  endtask

  // tvalid is lowered before the wait on the clock, so a request that follows
  // never raises it again in the same step.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_seg_count(int unsigned v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v[CFG_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.seg_count = v;
    cfg_valid <= 1'b0;
  endtask

  // A map is sent only when its search reads loaded segments; a glyph word it
  // would read is loaded first if it never was.
  task automatic request_map(bit [CODE_W-1:0] c);
    map_req_t      r;
    int            slot;
    bit            seg_ok;
    void'(sb.lookup(c, slot, seg_ok));
    if (!seg_ok) return;
    if (slot >= 0 && !sb.glyph_written[slot])
      push_req(glyph_load(unsigned'(slot), coin(12) ? 16'h0000 : CODE_W'($urandom)));
    r           = rand_req(OP_MAP);
    r.char_code = c;
    push_req(r);
  endtask

  // Sorted segments spread over the code space; the last is mostly the 0xFFFF sentinel, else a random end code.
  task automatic build_seg_table(int unsigned eff);
    int unsigned     step;
    int unsigned     k;
    int unsigned     span;
    int unsigned     pick;
    bit [CODE_W-1:0] s;
    bit [CODE_W-1:0] e;
    bit [CODE_W-1:0] ro;
    step = 65000 / eff;
    span = (step / 3 < 300) ? step / 3 : 300;
    for (k = 0; k + 1 < eff; k++) begin
      s = CODE_W'(k * step + $urandom_range(0, step / 3));
      e = CODE_W'(s + $urandom_range(0, span));
      if (coin(10)) s = CODE_W'(e + $urandom_range(1, 5));
      pick = $urandom_range(0, 19);
      if (pick < 8) ro = 16'h0000;
      else if (pick < 17)
        ro = CODE_W'(2 * (eff - k + $urandom_range(0, 1000)) + $urandom_range(0, 1));
      else if (pick < 18) ro = CODE_W'($urandom_range(1, 8));
      else ro = CODE_W'($urandom);
      push_req(seg_load(k, e, s, CODE_W'($urandom), ro));
    end
    if (coin(10)) begin
      push_req(seg_load(eff - 1, CODE_W'($urandom_range(0, 65534)), CODE_W'($urandom),
                        CODE_W'($urandom), coin(50) ? 16'h0000 : CODE_W'($urandom)));
    end else begin
      push_req(seg_load(eff - 1, SENTINEL_CODE,
                        coin(90) ? SENTINEL_CODE : CODE_W'($urandom),
                        CODE_W'($urandom), coin(50) ? 16'h0000 : CODE_W'($urandom)));
    end
  endtask

  function automatic bit [CODE_W-1:0] pick_code(int unsigned eff);
    int unsigned     k;
    int unsigned     r;
    bit [CODE_W-1:0] s;
    bit [CODE_W-1:0] e;
    if (eff == 0) return CODE_W'($urandom);
    k = $urandom_range(0, eff - 1);
    s = sb.start_mem[k];
    e = sb.end_mem[k];
    r = $urandom_range(0, 99);
    if (r < 3) return SENTINEL_CODE;
    if (r < 18) return CODE_W'($urandom);
    if (r < 33) begin
      case ($urandom_range(0, 2))
        0:       return e;
        1:       return e + 1'b1;
        default: return s - 1'b1;
      endcase
    end
    if (s <= e) return CODE_W'($urandom_range(e, s));
    return s;
  endfunction

  task automatic send_noise();
    map_req_t r;
    case ($urandom_range(0, 3))
      0: r = rand_req(OP_LOAD_SEG);
      1: r = rand_req(OP_LOAD_GLYPH);
      2: r = rand_req(OP_IGNORED);
      default: begin
        r       = rand_req(OP_LOAD_SEG);
        r.index = INDEX_W'($urandom_range(MAX_SEGMENTS, 1023));
      end
    endcase
    push_req(r);
  endtask

  task automatic run_phase(int unsigned count, int unsigned n_maps, bit rebuild,
                           bit long_hold, bit drain_pause);
    int unsigned eff;
    int unsigned i;
    eff = (count > MAX_SEGMENTS) ? MAX_SEGMENTS : count;
    write_seg_count(count);
    if (rebuild && eff > 0) build_seg_table(eff);
    for (i = 0; i < n_maps; i++) begin
      if (long_hold && i == n_maps / 3) hold_requests <= hold_requests + 1;
      if (drain_pause && i == n_maps / 2) wait_drained();
      if (coin(8)) send_noise();
      else request_map(pick_code(eff));
    end
  endtask

  task automatic directed_checks();
    map_req_t r;
    // Reset segment count of one: a single delta-mapped segment.
    push_req(seg_load(0, 16'h0100, 16'h0010, 16'h1000, 16'h0000));
    request_map(16'h0020);
    write_seg_count(3);
    // Delta wrap, a glyph-array segment and the sentinel.
    push_req(seg_load(0, 16'h0010, 16'h0005, 16'hFFFF, 16'h0000));
    push_req(seg_load(1, 16'h0100, 16'h0050, 16'h0005, 16'd24));
    push_req(seg_load(2, SENTINEL_CODE, SENTINEL_CODE, 16'h0001, 16'h0000));
    push_req(glyph_load(10, 16'h0000));
    push_req(glyph_load(11, 16'hFFFE));
    push_req(glyph_load(1023, 16'hFFFF));
    // Out-of-range segment load and the ignored request kind.
    r       = rand_req(OP_LOAD_SEG);
    r.index = 10'h3FF;
    push_req(r);
    push_req(rand_req(OP_IGNORED));
    request_map(16'h0000);
    request_map(16'h0005);
    request_map(16'h0010);
    request_map(16'h0011);
    request_map(16'h0050);
    request_map(16'h0051);
    request_map(16'h0200);
    request_map(SENTINEL_CODE);
    // Glyph array index below zero, then far beyond the store.
    push_req(seg_load(0, 16'h0010, 16'h0005, 16'hFFFF, 16'h0002));
    request_map(16'h0005);
    push_req(seg_load(1, 16'h0100, 16'h0050, 16'h0005, 16'hFFFF));
    request_map(16'h0050);
  endtask

  initial begin
    int unsigned counts [12];
    int unsigned p;
    int unsigned n_maps;
    counts = '{1, 4, 2, 9, 0, 16, 256, 511, 3, 24, 7, 12};
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_checks();
    for (p = 0; p < 12; p++) begin
      idle_mode <= idle_mode_t'(p % 4);
      n_maps = (counts[p] == 256) ? 30 : (counts[p] == 511) ? 20 : 50;
      // The 511 phase saturates to the table that the 256 phase left behind.
      run_phase(counts[p], n_maps, counts[p] != 511, p == 0, p == 5);
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d requests; %0d map results checked, %0d inside a segment,",
             sb.accepted, sb.maps_checked, sb.hits);
    $display("%0d past the glyph array; segment counts 0 to 511 under four idling patterns,",
             sb.array_misses);
    $display("a long output hold and a drain pause.");
    if (sb.pending.size() != 0)
      $display("%0d map results never arrived", sb.pending.size());
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
